// ===== rtl/core/integer_to_radix_digits_top_macros.svh =====
// Assertion macros shared by the integer-to-radix-digits RTL.
`ifndef INTEGER_TO_RADIX_DIGITS_TOP_MACROS_SVH
`define INTEGER_TO_RADIX_DIGITS_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define ITRD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("itrd assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define ITRD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("itrd assertion failed");

`endif

// ===== rtl/core/itrd_pkg.sv =====
// Types, constants and the digit glyph function of the radix conversion block.
package itrd_pkg;

  localparam int VALUE_W        = 31;
  localparam int RADIX_W        = 5;
  localparam int DIGIT_W        = 4;
  localparam int CHAR_W         = 7;
  localparam int STEP_W         = $clog2(VALUE_W);
  localparam int MAX_DIGITS_DEF = 32;

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(16);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);

  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = DIGIT_W'(10);
  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = CHAR_W'(8'h30);
  localparam logic [CHAR_W-1:0]  CHAR_ALPHA = CHAR_W'(8'h41);

  // Request from the sequencer to the divider.
  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] dividend;
    logic [RADIX_W-1:0] divisor;
  } div_ctrl_t;

  // Status from the divider back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // ASCII glyph of one digit: '0'-'9', then 'A'-'F'.
  function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_TEN) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_ALPHA + CHAR_W'(d - DIGIT_TEN);
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/itrd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module itrd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/itrd_divider.sv =====
// Bit-serial restoring divider: one quotient bit per cycle by a small radix.
module itrd_divider
(
  input  logic                                clk,
  input  logic                                rst_n,
  input  itrd_pkg::div_ctrl_t                 ctrl,
  output itrd_pkg::div_stat_t                 stat,
  output logic [itrd_pkg::VALUE_W-1:0]        quotient,
  output logic [itrd_pkg::DIGIT_W-1:0]        remainder
);
  import itrd_pkg::*;

  logic [VALUE_W-1:0] dvd_r, dvd_nxt;
  logic [DIGIT_W-1:0] rem_r, rem_nxt;
  logic [RADIX_W-1:0] dsr_r, dsr_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [RADIX_W-1:0] trial;
  logic               fits;

  // One restoring step: shift in the next dividend bit and try a subtract.
  // The remainder stays below the divisor, so it fits in one digit.
  assign trial = {rem_r, dvd_r[VALUE_W-1]};
  assign fits  = (trial >= dsr_r);

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctrl.start) begin
      dvd_nxt  = ctrl.dividend;
      rem_nxt  = '0;
      dsr_nxt  = ctrl.divisor;
      step_nxt = STEP_W'(VALUE_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[VALUE_W-2:0], fits};
      rem_nxt = fits ? DIGIT_W'(trial - dsr_r) : DIGIT_W'(trial);
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
    step_r <= step_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = dvd_r;
  assign remainder = rem_r;

endmodule

// ===== rtl/core/integer_to_radix_digits_top.sv =====
// Top level of the integer to radix digit string converter.
//
// Usage: write the radix (2..16; 0 and 1 act as 2, 17..31 act as 16) on
// cfg_wr_en/cfg_wr_data while no conversion is in progress. Each item on
// the in_ stream is a 31-bit non-negative value. For each item the out_
// stream carries its ASCII digits, most significant first, one item per
// character, with out_tlast on the final digit. Zero gives a single '0'.
// Conversion divides the value by the radix repeatedly in one shared
// bit-serial divider, and each remainder is stored as a digit in a small
// RAM. The digits are then read back through its registered read port,
// one character at a time, alternating a read state and a load state.
// in_tready is high again once the last character sits in the output
// register. in_tready is high only while the block is idle; one item is
// converted at a time. The output register holds a character until
// out_tready takes it, and the sequencer waits meanwhile. Reset sets the
// radix to 16 and returns the block to idle with the output empty.
module integer_to_radix_digits_top #(
  parameter int MAX_DIGITS = itrd_pkg::MAX_DIGITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // in_tdata: [30:0] value, [31] zero pad
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [31:0]                  in_tdata,
  // out_tdata: [6:0] digit_char, [7] zero pad
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [7:0]                   out_tdata,
  output logic                         out_tlast,
  input  logic                         cfg_wr_en,
  input  logic [itrd_pkg::RADIX_W-1:0] cfg_wr_data
);
  import itrd_pkg::*;

  `include "integer_to_radix_digits_top_macros.svh"

  localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int ADDR_W = $clog2(MAX_DIGITS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_READ = 4'b0100,
    S_LOAD = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [RADIX_W-1:0] radix_r;
  logic [RADIX_W-1:0] eff_radix;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [ADDR_W-1:0]  pos_r, pos_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;

  div_ctrl_t          div_ctrl;
  div_stat_t          div_stat;
  logic [VALUE_W-1:0] div_quot;
  logic [DIGIT_W-1:0] div_rem;

  logic               ram_we;
  logic               ram_re;
  logic [DIGIT_W-1:0] ram_rdata;
  logic               in_fire;
  logic               slot_free;

  // Radix register; out-of-range settings clamp to the nearest legal radix.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_wr_en) begin
      radix_r <= cfg_wr_data;
    end
  end

  always_comb begin
    priority if (radix_r < RADIX_MIN) begin
      eff_radix = RADIX_MIN;
    end else if (radix_r > RADIX_MAX) begin
      eff_radix = RADIX_MAX;
    end else begin
      eff_radix = radix_r;
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  // Sequencer: divide until the quotient is zero or MAX_DIGITS digits are stored, then read digits back.
  always_comb begin
    state_nxt         = state_r;
    count_nxt         = count_r;
    pos_nxt           = pos_r;
    out_valid_nxt     = out_valid_r && !out_tready;
    out_char_nxt      = out_char_r;
    out_last_nxt      = out_last_r;
    div_ctrl.start    = 1'b0;
    div_ctrl.dividend = in_tdata[VALUE_W-1:0];
    div_ctrl.divisor  = eff_radix;
    ram_we            = 1'b0;
    ram_re            = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          div_ctrl.start = 1'b1;
          count_nxt      = '0;
          state_nxt      = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          ram_we    = 1'b1;
          count_nxt = count_r + 1'b1;
          if ((div_quot == '0) || (count_nxt == CNT_W'(MAX_DIGITS))) begin
            pos_nxt   = count_r[ADDR_W-1:0];
            state_nxt = S_READ;
          end else begin
            div_ctrl.start    = 1'b1;
            div_ctrl.dividend = div_quot;
          end
        end
      end
      S_READ: begin
        ram_re    = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_glyph(ram_rdata);
          out_last_nxt  = (pos_r == '0);
          if (pos_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            pos_nxt   = pos_r - 1'b1;
            state_nxt = S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // Shared bit-serial divider.
  itrd_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (div_ctrl),
    .stat      (div_stat),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // Digit store, least significant digit at address zero.
  itrd_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_digit_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (div_rem),
    .re    (ram_re),
    .raddr (pos_r),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_char_r};
  assign out_tlast  = out_last_r;

  // Checks on the sequencer and divider handoff.
  `ITRD_ASSERT_IMP(a_done_only_in_div, div_stat.done, state_r == S_DIV)
  `ITRD_ASSERT_NXT(a_accept_starts_div, in_fire, div_stat.busy && (state_r == S_DIV))
  `ITRD_ASSERT_IMP(a_count_bounded, 1'b1, count_r <= CNT_W'(MAX_DIGITS))
  `ITRD_ASSERT_NXT(a_load_fills_output, (state_r == S_LOAD) && slot_free, out_valid_r)

endmodule
